>>> rtl/mpn_pkg.sv
// Shared types, constants and codes for the mean pooling and L2 normalisation block.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package mpn_pkg;

   // Sizes of the feature store and the frame count limit.
   localparam int DimMax    = 1024;
   localparam int MaxFrames = 4096;

   // Field and datapath widths.
   localparam int IdxW  = 10;
   localparam int LenW  = 11;
   localparam int FrmW  = 13;
   localparam int SumW  = 36;
   localparam int ValW  = 24;
   localparam int NormW = 32;
   localparam int SqW   = 57;
   localparam int RootW = 58;
   localparam int DivNW = 47;
   localparam int DivDW = 34;
   localparam int DivCntW = 6;
   localparam int AddrW = 3;

   localparam logic [LenW-1:0] DimMaxLen   = LenW'(DimMax);
   localparam logic [LenW-1:0] VecLenReset = LenW'(1024);
   localparam logic [FrmW-1:0] FrameLimit  = FrmW'(MaxFrames);

   localparam logic signed [SumW:0] SumMax = 37'sh07FFFFFFFF;
   localparam logic signed [SumW:0] SumMin = -37'sh0800000000;
   localparam logic [DivNW-1:0] MeanPosMax = DivNW'(8388607);
   localparam logic [DivNW-1:0] MeanNegMax = DivNW'(8388608);
   localparam logic [DivNW-1:0] OneQ22     = DivNW'(4194304);
   localparam logic [RootW-1:0] RootBitTop = RootW'(1) << 56;

   // Register index decoded from the configuration address.
   localparam logic CsrVecLen = 1'b0;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_CLIP   = 3'd1,
      ST_PARTIAL   = 3'd2,
      ST_BAD_INDEX = 3'd3,
      ST_SATURATED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_ACCUM,
      OP_ACCUM_LAST,
      OP_READ
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ACC_WR,
      S_FIN_BEGIN,
      S_FIN_RD,
      S_FIN_DIV,
      S_FIN_WAIT,
      S_FIN_SQ,
      S_FIN_ACC,
      S_SQRT,
      S_RD_DIV,
      S_RD_WAIT,
      S_RD_OUT
   } state_type;

   typedef struct packed {
      logic                   kind;
      logic signed [ValW-1:0] element_value;
      logic                   final_element;
      logic [IdxW-1:0]        read_index;
   } req_type;

   typedef struct packed {
      logic signed [ValW-1:0] pooled_value;
      logic [2:0]             status;
   } rsp_type;

   // One classified command between the front end and the back end.
   typedef struct packed {
      op_type                 op;
      logic signed [ValW-1:0] value;
      logic [IdxW-1:0]        index;
      logic [LenW-1:0]        len;
   } cmd_type;

   typedef struct packed {
      logic             start;
      logic [DivNW-1:0] num;
      logic [DivDW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DivNW-1:0] quot;
   } div_rsp_type;

endpackage

>>> rtl/mpn_front.sv
// Front end: classifies each incoming word into a command and attaches the clamped length.
// Depends on mpn_pkg.
`timescale 1ns / 1ps

module mpn_front (
   input  mpn_pkg::req_type               req_data,
   input  logic [mpn_pkg::LenW-1:0]       vec_len,
   output mpn_pkg::cmd_type               cmd
);
   import mpn_pkg::*;

   logic [LenW-1:0] len_used;

   // A length of zero acts as one, anything above the store size as the store size.
   always_comb begin
      if (vec_len == '0) begin
         len_used = LenW'(1);
      end else if (vec_len > DimMaxLen) begin
         len_used = DimMaxLen;
      end else begin
         len_used = vec_len;
      end
   end

   // Decode the word kind and the final marker into one operation.
   always_comb begin
      cmd.value = req_data.element_value;
      cmd.index = req_data.read_index;
      cmd.len   = len_used;
      if (req_data.kind) begin
         cmd.op = OP_READ;
      end else if (req_data.final_element) begin
         cmd.op = OP_ACCUM_LAST;
      end else begin
         cmd.op = OP_ACCUM;
      end
   end

endmodule

>>> rtl/mpn_fifo.sv
// Two-entry command queue between the front end and the back end.
// Depends on mpn_pkg.
`timescale 1ns / 1ps

module mpn_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mpn_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output mpn_pkg::cmd_type head
);
   import mpn_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/mpn_div.sv
// Restoring divider, one quotient bit per cycle, shared by mean and normalisation.
// Depends on mpn_pkg.
`timescale 1ns / 1ps

module mpn_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mpn_pkg::div_req_type div_req,
   output mpn_pkg::div_rsp_type div_rsp
);
   import mpn_pkg::*;

   logic [DivDW-1:0]   rem_ff, rem_in;
   logic [DivNW-1:0]   quo_ff, quo_in;
   logic [DivDW-1:0]   den_ff, den_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DivDW:0]     trial;
   logic [DivDW:0]     diff;
   logic               fits;

   // One trial subtraction of the shifted remainder.
   always_comb begin
      trial = {rem_ff, quo_ff[DivNW-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});
   end

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.num;
         den_in  = div_req.den;
         cnt_in  = DivCntW'(DivNW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DivDW-1:0] : trial[DivDW-1:0];
         quo_in = {quo_ff[DivNW-2:0], fits};
         cnt_in = cnt_ff - DivCntW'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;

endmodule

>>> rtl/mpn_back.sv
// Back end: accumulation store, clip finalisation with square root, and normalised reads.
// Depends on mpn_pkg; drives the shared divider mpn_div.
`timescale 1ns / 1ps

module mpn_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  mpn_pkg::cmd_type     cmd,
   output logic                 cmd_pop,
   output logic                 rsp_valid,
   output mpn_pkg::rsp_type     rsp_data,
   input  logic                 rsp_stall,
   output mpn_pkg::div_req_type div_req,
   input  mpn_pkg::div_rsp_type div_rsp
);
   import mpn_pkg::*;

   // Sum store: sums during a clip, means once the clip is finalised.
   logic signed [SumW-1:0] sum_mem [DimMax];
   logic signed [SumW-1:0] rdata_ff;
   logic                   mem_re;
   logic [IdxW-1:0]        mem_raddr;
   logic                   mem_we;
   logic [IdxW-1:0]        mem_waddr;
   logic signed [SumW-1:0] mem_wdata;

   state_type              state_ff, state_in;
   logic [IdxW-1:0]        elem_cnt_ff, elem_cnt_in;
   logic [FrmW-1:0]        frame_cnt_ff, frame_cnt_in;
   logic                   clip_active_ff, clip_active_in;
   logic                   frames_sat_ff, frames_sat_in;
   logic                   clip_done_ff, clip_done_in;
   status_type             clip_status_ff, clip_status_in;
   logic [LenW-1:0]        done_len_ff, done_len_in;
   logic [NormW-1:0]       norm_ff, norm_in;
   logic [LenW-1:0]        fill_ff, fill_in;
   logic [IdxW-1:0]        cur_idx_ff, cur_idx_in;
   logic signed [ValW-1:0] cur_val_ff, cur_val_in;
   logic [LenW-1:0]        fin_len_ff, fin_len_in;
   logic                   last_ff, last_in;
   logic                   neg_ff, neg_in;
   logic signed [ValW-1:0] mean_ff, mean_in;
   logic [2*ValW-1:0]      prod_ff, prod_in;
   logic [SqW-1:0]         sumsq_ff, sumsq_in;
   logic [RootW-1:0]       root_rem_ff, root_rem_in;
   logic [RootW-1:0]       root_res_ff, root_res_in;
   logic [RootW-1:0]       root_bit_ff, root_bit_in;
   logic signed [ValW-1:0] val_ff, val_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   out_free;
   logic                   start_clip;
   logic [IdxW-1:0]        ec;
   logic [LenW-1:0]        ec_next;
   logic [FrmW-1:0]        fc;
   logic                   sat;
   logic                   read_ok;
   logic signed [SumW-1:0] old_sum;
   logic signed [SumW:0]   new_sum;
   logic [SumW-1:0]        sum_mag;
   logic [ValW-1:0]        mean_mag;
   logic signed [2*ValW-1:0] sq_full;
   logic [SqW-1:0]         sumsq_next;
   logic [RootW-1:0]       root_try;
   logic [RootW-1:0]       root_res_next;
   status_type             read_status;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Datapath helpers used by several states.
   always_comb begin
      old_sum    = ({1'b0, cur_idx_ff} < fill_ff) ? rdata_ff : '0;
      new_sum    = {old_sum[SumW-1], old_sum} + (SumW+1)'(cur_val_ff);
      sum_mag    = old_sum[SumW-1] ? SumW'(-old_sum) : SumW'(old_sum);
      mean_mag   = rdata_ff[ValW-1] ? ValW'(-rdata_ff[ValW-1:0]) : rdata_ff[ValW-1:0];
      sq_full    = mean_ff * mean_ff;
      sumsq_next = sumsq_ff + SqW'(prod_ff);
      root_try   = root_res_ff + root_bit_ff;
      if (root_rem_ff >= root_try) begin
         root_res_next = (root_res_ff >> 1) + root_bit_ff;
      end else begin
         root_res_next = root_res_ff >> 1;
      end
   end

   // Clip start and frame position for an element word at the head of the queue.
   always_comb begin
      start_clip = !clip_active_ff;
      ec  = start_clip ? '0 : elem_cnt_ff;
      fc  = start_clip ? '0 : frame_cnt_ff;
      sat = start_clip ? 1'b0 : frames_sat_ff;
      if ({1'b0, ec} >= cmd.len) begin
         ec = '0;
      end
      ec_next = LenW'(ec) + LenW'(1);
   end

   // Error checks for a read word, in priority order.
   always_comb begin
      read_ok = 1'b0;
      if (!clip_done_ff) begin
         read_status = ST_NO_CLIP;
      end else if (clip_status_ff == ST_PARTIAL) begin
         read_status = ST_PARTIAL;
      end else if ({1'b0, cmd.index} >= done_len_ff) begin
         read_status = ST_BAD_INDEX;
      end else begin
         read_status = clip_status_ff;
         read_ok     = 1'b1;
      end
   end

   // Sequencer: next state and datapath control.
   always_comb begin
      state_in       = state_ff;
      elem_cnt_in    = elem_cnt_ff;
      frame_cnt_in   = frame_cnt_ff;
      clip_active_in = clip_active_ff;
      frames_sat_in  = frames_sat_ff;
      clip_done_in   = clip_done_ff;
      clip_status_in = clip_status_ff;
      done_len_in    = done_len_ff;
      norm_in        = norm_ff;
      fill_in        = fill_ff;
      cur_idx_in     = cur_idx_ff;
      cur_val_in     = cur_val_ff;
      fin_len_in     = fin_len_ff;
      last_in        = last_ff;
      neg_in         = neg_ff;
      mean_in        = mean_ff;
      prod_in        = prod_ff;
      sumsq_in       = sumsq_ff;
      root_rem_in    = root_rem_ff;
      root_res_in    = root_res_ff;
      root_bit_in    = root_bit_ff;
      val_in         = val_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      cmd_pop        = 1'b0;
      mem_re         = 1'b0;
      mem_raddr      = '0;
      mem_we         = 1'b0;
      mem_waddr      = cur_idx_ff;
      mem_wdata      = '0;
      div_req.start  = 1'b0;
      div_req.num    = '0;
      div_req.den    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               if (cmd.op == OP_READ) begin
                  if (read_ok) begin
                     cmd_pop   = 1'b1;
                     mem_re    = 1'b1;
                     mem_raddr = cmd.index;
                     state_in  = S_RD_DIV;
                  end else if (out_free) begin
                     cmd_pop                  = 1'b1;
                     rsp_valid_in             = 1'b1;
                     rsp_data_in.pooled_value = '0;
                     rsp_data_in.status       = read_status;
                  end
               end else begin
                  cmd_pop    = 1'b1;
                  last_in    = (cmd.op == OP_ACCUM_LAST);
                  fin_len_in = cmd.len;
                  if (start_clip) begin
                     clip_done_in   = 1'b0;
                     clip_status_in = ST_NO_CLIP;
                     clip_active_in = 1'b1;
                     fill_in        = '0;
                  end
                  // Frames past the limit are counted as saturation and not added.
                  frames_sat_in = sat || (fc >= FrameLimit);
                  if (ec_next >= cmd.len) begin
                     elem_cnt_in  = '0;
                     frame_cnt_in = (fc < FrameLimit) ? fc + FrmW'(1) : fc;
                  end else begin
                     elem_cnt_in  = ec_next[IdxW-1:0];
                     frame_cnt_in = fc;
                  end
                  if (fc < FrameLimit) begin
                     mem_re     = 1'b1;
                     mem_raddr  = ec;
                     cur_idx_in = ec;
                     cur_val_in = cmd.value;
                     state_in   = S_ACC_WR;
                  end else if (cmd.op == OP_ACCUM_LAST) begin
                     state_in = S_FIN_BEGIN;
                  end
               end
            end
         end

         // Saturating add into the store; entries past the fill mark read as zero.
         S_ACC_WR: begin
            mem_we = 1'b1;
            if (new_sum > SumMax) begin
               mem_wdata = SumW'(SumMax);
            end else if (new_sum < SumMin) begin
               mem_wdata = SumW'(SumMin);
            end else begin
               mem_wdata = SumW'(new_sum);
            end
            if (LenW'(cur_idx_ff) + LenW'(1) > fill_ff) begin
               fill_in = LenW'(cur_idx_ff) + LenW'(1);
            end
            state_in = last_ff ? S_FIN_BEGIN : S_IDLE;
         end

         S_FIN_BEGIN: begin
            done_len_in    = fin_len_ff;
            clip_done_in   = 1'b1;
            clip_active_in = 1'b0;
            if (elem_cnt_ff != '0 || frame_cnt_ff == '0) begin
               clip_status_in = ST_PARTIAL;
               norm_in        = NormW'(1);
               state_in       = S_IDLE;
            end else begin
               cur_idx_in = '0;
               sumsq_in   = '0;
               state_in   = S_FIN_RD;
            end
         end

         S_FIN_RD: begin
            mem_re    = 1'b1;
            mem_raddr = cur_idx_ff;
            state_in  = S_FIN_DIV;
         end

         // Rounded mean: (2|sum| + frames) / (2 frames).
         S_FIN_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = DivNW'({sum_mag, 1'b0}) + DivNW'(frame_cnt_ff);
            div_req.den   = DivDW'({frame_cnt_ff, 1'b0});
            neg_in        = old_sum[SumW-1];
            state_in      = S_FIN_WAIT;
         end

         S_FIN_WAIT: begin
            if (div_rsp.done) begin
               if (neg_ff) begin
                  mean_in = (div_rsp.quot > MeanNegMax) ? ValW'(MeanNegMax)
                                                        : ValW'(-div_rsp.quot[ValW-1:0]);
               end else begin
                  mean_in = (div_rsp.quot > MeanPosMax) ? ValW'(MeanPosMax)
                                                        : div_rsp.quot[ValW-1:0];
               end
               state_in = S_FIN_SQ;
            end
         end

         S_FIN_SQ: begin
            prod_in   = sq_full;
            mem_we    = 1'b1;
            mem_wdata = SumW'(mean_ff);
            state_in  = S_FIN_ACC;
         end

         S_FIN_ACC: begin
            sumsq_in = sumsq_next;
            if (LenW'(cur_idx_ff) + LenW'(1) == fin_len_ff) begin
               root_rem_in = RootW'(sumsq_next);
               root_res_in = '0;
               root_bit_in = RootBitTop;
               state_in    = S_SQRT;
            end else begin
               cur_idx_in = cur_idx_ff + IdxW'(1);
               state_in   = S_FIN_RD;
            end
         end

         // Integer square root, two bits of the radicand per cycle.
         S_SQRT: begin
            if (root_rem_ff >= root_try) begin
               root_rem_in = root_rem_ff - root_try;
            end
            root_res_in = root_res_next;
            root_bit_in = root_bit_ff >> 2;
            if (root_bit_ff[0]) begin
               norm_in        = (root_res_next == '0) ? NormW'(1) : root_res_next[NormW-1:0];
               clip_status_in = frames_sat_ff ? ST_SATURATED : ST_OK;
               fill_in        = fin_len_ff;
               state_in       = S_IDLE;
            end
         end

         // Normalised value: (2|mean| 2^22 + norm) / (2 norm).
         S_RD_DIV: begin
            div_req.start = 1'b1;
            div_req.num   = DivNW'({mean_mag, 23'b0}) + DivNW'(norm_ff);
            div_req.den   = DivDW'({norm_ff, 1'b0});
            neg_in        = rdata_ff[ValW-1];
            state_in      = S_RD_WAIT;
         end

         S_RD_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.quot > OneQ22) begin
                  val_in = neg_ff ? -ValW'(OneQ22) : ValW'(OneQ22);
               end else begin
                  val_in = neg_ff ? ValW'(-div_rsp.quot[ValW-1:0]) : div_rsp.quot[ValW-1:0];
               end
               state_in = S_RD_OUT;
            end
         end

         S_RD_OUT: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.pooled_value = val_ff;
               rsp_data_in.status       = clip_status_ff;
               state_in                 = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         elem_cnt_ff    <= '0;
         frame_cnt_ff   <= '0;
         clip_active_ff <= 1'b0;
         frames_sat_ff  <= 1'b0;
         clip_done_ff   <= 1'b0;
         clip_status_ff <= ST_NO_CLIP;
         done_len_ff    <= '0;
         norm_ff        <= '0;
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         elem_cnt_ff    <= elem_cnt_in;
         frame_cnt_ff   <= frame_cnt_in;
         clip_active_ff <= clip_active_in;
         frames_sat_ff  <= frames_sat_in;
         clip_done_ff   <= clip_done_in;
         clip_status_ff <= clip_status_in;
         done_len_ff    <= done_len_in;
         norm_ff        <= norm_in;
         fill_ff        <= fill_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Working registers without reset.
   always_ff @(posedge clock) begin
      cur_idx_ff  <= cur_idx_in;
      cur_val_ff  <= cur_val_in;
      fin_len_ff  <= fin_len_in;
      last_ff     <= last_in;
      neg_ff      <= neg_in;
      mean_ff     <= mean_in;
      prod_ff     <= prod_in;
      sumsq_ff    <= sumsq_in;
      root_rem_ff <= root_rem_in;
      root_res_ff <= root_res_in;
      root_bit_ff <= root_bit_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Store with one write and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= sum_mem[mem_raddr];
      end
   end

endmodule

>>> rtl/mean_pool_l2_normalize.sv
// Top level of the mean pooling and L2 normalisation block with its configuration register.
// Depends on mpn_pkg, mpn_front, mpn_fifo, mpn_back and mpn_div.
`timescale 1ns / 1ps

// Frame elements (Q7.16) are summed per dimension in a 1024-entry store; the word marked
// final closes the clip, after which read words return mean / norm in Q1.22 with a status.
// A front end classifies each word into a two-entry queue, so input is taken while the back
// end works. An element word is handled as a store read, then a saturating add and write
// back. Finalisation walks the clip's dimensions through the shared bit-serial divider
// and then takes the square root of the sum of squared means. A read with an error status
// is answered without the store or the divider; a valid read goes through the store and
// the 47-step divider. The store needs no clearing pass after reset: a fill mark tells
// written entries from stale ones. The vector length lies at byte address 0.
module mean_pool_l2_normalize (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  mpn_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output mpn_pkg::rsp_type            rsp_data,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [mpn_pkg::AddrW-1:0]   csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import mpn_pkg::*;

   logic [LenW-1:0] vec_len_ff, vec_len_in;
   logic            csr_write;
   cmd_type         front_cmd;
   cmd_type         head_cmd;
   logic            q_full;
   logic            q_empty;
   logic            q_pop;
   div_req_type     div_req;
   div_rsp_type     div_rsp;

   // Configuration register; writes to unknown addresses are dropped.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      vec_len_in = vec_len_ff;
      if (csr_write && csr_paddr[2] == CsrVecLen) begin
         vec_len_in = csr_pwdata[LenW-1:0];
      end
      csr_prdata = (csr_paddr[2] == CsrVecLen) ? 32'(vec_len_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_len_ff <= VecLenReset;
      end else begin
         vec_len_ff <= vec_len_in;
      end
   end

   assign req_stall = q_full;

   mpn_front u_front (
      .req_data (req_data),
      .vec_len  (vec_len_ff),
      .cmd      (front_cmd)
   );

   mpn_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_data (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (head_cmd)
   );

   mpn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (!q_empty),
      .cmd       (head_cmd),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   mpn_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // The queue is never popped when empty.
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !q_empty)
      else $error("command queue popped while empty");

   // Error statuses always carry a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK && rsp_data.status != ST_SATURATED
      |-> rsp_data.pooled_value == '0)
      else $error("error status with non-zero value");

   // Normalised values stay within plus or minus one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pooled_value <= 24'sd4194304
                     && rsp_data.pooled_value >= -24'sd4194304))
      else $error("normalised value out of range");

   // A register write is visible on the read data in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_paddr[2] == CsrVecLen ##1 csr_paddr[2] == CsrVecLen
      |-> csr_prdata[LenW-1:0] == $past(csr_pwdata[LenW-1:0]))
      else $error("configuration write not visible");

endmodule
